>>> hw/rtl/npq_pkg.sv
package npq_pkg;

  localparam int OCT_W       = 3;
  localparam int NUM_OCT     = 8;
  localparam int CHAN_W      = 8;
  localparam int SQ_W        = 16;
  localparam int DIST_W      = 18;
  localparam int QUEUE_DEPTH = 2;
  localparam int ENTRY_W     = 40;

  // squared distance must stay strictly below 255*255 to qualify
  localparam logic [DIST_W-1:0] DIST_LIMIT = 18'd65025;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_CONVERT = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } back_state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  entry_glyph;
    logic [7:0]  entry_attribute;
    logic        frame_end;
  } item_t;

  typedef struct packed {
    logic [7:0]  glyph_out;
    logic [7:0]  attribute_out;
    status_e     status;
    logic        frame_end_out;
  } result_t;

  // classified transaction as it waits in the queue
  typedef struct packed {
    cmd_e              cmd;
    logic [OCT_W-1:0]  oct;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        glyph;
    logic [7:0]        attr;
    logic              frame_end;
  } qent_t;

  // queue handshake between back end and queue
  typedef struct packed {
    logic vld;
    logic pop;
  } qctl_t;

endpackage

>>> hw/rtl/nearest_palette_color_quantizer_top.sv
// nearest palette color quantizer
// command channel: start_i with item_i; a transaction is taken at a rising edge
//   where start_i is high and busy_o is low. cmd load appends an entry to the
//   octant bucket of its color, cmd convert looks up the nearest entry of the
//   pixel's octant bucket
// result channel: one result per transaction, on result_o for exactly one
//   cycle while valid_o is high; the receiver cannot stall it
// a two-entry queue parts the classifying front end from the back end, so
//   commands keep arriving while a convert scans
// a load passes through the queue and then the result register, as does a
//   convert into an empty bucket; any other convert reads its bucket entry
//   by entry in ST_SCAN, each read through the store read register and the
//   squared difference register into the compare, then the result register
// throughput: one load per cycle while the back end is idle; a convert holds
//   the back end while it reads its bucket from the single-port palette store
// reset: bucket fill counts, queue and result strobe clear at once; the
//   palette store holds no valid content until loaded
module nearest_palette_color_quantizer_top
  import npq_pkg::*;
#(
  parameter int BUCKET_DEPTH = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  item_t   item_i,
  output logic    busy_o,
  output logic    valid_o,
  output result_t result_o
);

  // front end to queue
  logic  push;
  logic  q_full;
  qent_t push_entry;

  // queue to back end
  logic  q_vld;
  qent_t head;
  qctl_t qctl;

  npq_front u_front (
    .start_i (start_i),
    .item_i  (item_i),
    .full_i  (q_full),
    .busy_o  (busy_o),
    .push_o  (push),
    .entry_o (push_entry)
  );

  npq_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (qctl.pop),
    .vld_o   (q_vld),
    .head_o  (head)
  );

  // back end owns the palette store and bucket counts
  npq_back #(
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_vld_i (q_vld),
    .head_i     (head),
    .qctl_o     (qctl),
    .valid_o    (valid_o),
    .result_o   (result_o)
  );

endmodule

>>> hw/rtl/npq_front.sv
module npq_front
  import npq_pkg::*;
(
  input  logic  start_i,
  input  item_t item_i,
  input  logic  full_i,
  output logic  busy_o,
  output logic  push_o,
  output qent_t entry_o
);

  function automatic logic [OCT_W-1:0] octant(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
    // msb of each channel is the >=128 test
    octant = {r[7], g[7], b[7]};
  endfunction

  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

  always_comb begin
    entry_o.cmd       = item_i.cmd;
    entry_o.oct       = octant(item_i.red, item_i.green, item_i.blue);
    entry_o.red       = item_i.red;
    entry_o.green     = item_i.green;
    entry_o.blue      = item_i.blue;
    entry_o.glyph     = item_i.entry_glyph;
    entry_o.attr      = item_i.entry_attribute;
    entry_o.frame_end = item_i.frame_end;
  end

endmodule

>>> hw/rtl/npq_fifo.sv
module npq_fifo
  import npq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t entry_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  vld_o,
  output qent_t head_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  qent_t         mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
  assign vld_o   = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(QUEUE_DEPTH - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + PW'(1);
    end
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> hw/rtl/npq_back.sv
module npq_back
  import npq_pkg::*;
#(
  parameter int BUCKET_DEPTH = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    head_vld_i,
  input  qent_t   head_i,
  output qctl_t   qctl_o,
  output logic    valid_o,
  output result_t result_o
);

  localparam int JW    = $clog2(BUCKET_DEPTH + 1);
  localparam int DEPTH = NUM_OCT * BUCKET_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  back_state_e state_q, state_d;

  logic [JW-1:0]     fill_q [NUM_OCT];
  logic [JW-1:0]     fill_sel;
  logic [JW-1:0]     j_q, j_d;
  logic [JW-1:0]     n_q, n_d;
  logic [OCT_W-1:0]  oct_q, oct_d;
  logic [7:0]        pr_q, pr_d, pg_q, pg_d, pb_q, pb_d;
  logic              fe_q, fe_d;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] rd_q;
  logic               rd_vld_q, rd_vld_d, rd_first_q, rd_first_d, rd_last_q, rd_last_d;

  logic [SQ_W-1:0]    sq_r_q, sq_g_q, sq_b_q;
  logic [7:0]         s2_glyph_q, s2_attr_q;
  logic               s2_vld_q, s2_first_q, s2_last_q;

  logic [DIST_W-1:0]  best_q, best_d, best_cur, dist_sum;
  logic [7:0]         pick_glyph_q, pick_glyph_d, pick_attr_q, pick_attr_d;
  logic               take;

  logic               pop, fill_inc;
  logic               valid_d;
  logic               valid_q;
  result_t            res_q, res_d;

  assign fill_sel = fill_q[head_i.oct];
  assign pop      = (state_q == ST_IDLE) && head_vld_i;

  assign qctl_o.vld = head_vld_i;
  assign qctl_o.pop = pop;
  assign valid_o    = valid_q;
  assign result_o   = res_q;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d       = (a >= b) ? (a - b) : (b - a);
    sq_diff = SQ_W'(d) * SQ_W'(d);
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop && head_i.cmd == CMD_CONVERT && fill_sel != '0) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (j_q == n_q - JW'(1)) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (s2_vld_q && s2_last_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // compare stage
  always_comb begin
    dist_sum = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);
    best_cur = s2_first_q ? DIST_LIMIT : best_q;
    take     = dist_sum < best_cur;
    best_d   = best_q;
    pick_glyph_d = pick_glyph_q;
    pick_attr_d  = pick_attr_q;
    if (s2_vld_q) begin
      best_d = take ? dist_sum : best_cur;
      // entry 0 stands unless a qualifying entry is found
      if (take || s2_first_q) begin
        pick_glyph_d = s2_glyph_q;
        pick_attr_d  = s2_attr_q;
      end
    end
  end

  // outputs and datapath
  always_comb begin
    j_d        = j_q;
    n_d        = n_q;
    oct_d      = oct_q;
    pr_d       = pr_q;
    pg_d       = pg_q;
    pb_d       = pb_q;
    fe_d       = fe_q;
    mem_we     = 1'b0;
    mem_addr   = AW'(oct_q) * AW'(BUCKET_DEPTH) + AW'(j_q);
    mem_wdata  = {head_i.red, head_i.green, head_i.blue, head_i.glyph, head_i.attr};
    rd_vld_d   = 1'b0;
    rd_first_d = 1'b0;
    rd_last_d  = 1'b0;
    fill_inc   = 1'b0;
    valid_d    = 1'b0;
    res_d      = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          res_d.glyph_out     = '0;
          res_d.attribute_out = '0;
          res_d.status        = STATUS_OK;
          res_d.frame_end_out = head_i.frame_end;
          if (head_i.cmd == CMD_LOAD) begin
            valid_d = 1'b1;
            if (fill_sel >= JW'(BUCKET_DEPTH)) begin
              res_d.status = STATUS_FULL;
            end else begin
              mem_we   = 1'b1;
              mem_addr = AW'(head_i.oct) * AW'(BUCKET_DEPTH) + AW'(fill_sel);
              fill_inc = 1'b1;
            end
          end else if (fill_sel == '0) begin
            valid_d      = 1'b1;
            res_d.status = STATUS_EMPTY;
          end else begin
            j_d   = '0;
            n_d   = fill_sel;
            oct_d = head_i.oct;
            pr_d  = head_i.red;
            pg_d  = head_i.green;
            pb_d  = head_i.blue;
            fe_d  = head_i.frame_end;
          end
        end
      end
      ST_SCAN: begin
        rd_vld_d   = 1'b1;
        rd_first_d = (j_q == '0);
        rd_last_d  = (j_q == n_q - JW'(1));
        j_d        = j_q + JW'(1);
      end
      ST_FLUSH: begin
        if (s2_vld_q && s2_last_q) begin
          valid_d             = 1'b1;
          res_d.glyph_out     = pick_glyph_d;
          res_d.attribute_out = pick_attr_d;
          res_d.status        = STATUS_OK;
          res_d.frame_end_out = fe_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      valid_q  <= 1'b0;
      for (int k = 0; k < NUM_OCT; k++) begin
        fill_q[k] <= '0;
      end
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      s2_vld_q <= rd_vld_q;
      valid_q  <= valid_d;
      if (fill_inc) begin
        fill_q[head_i.oct] <= fill_sel + JW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    j_q          <= j_d;
    n_q          <= n_d;
    oct_q        <= oct_d;
    pr_q         <= pr_d;
    pg_q         <= pg_d;
    pb_q         <= pb_d;
    fe_q         <= fe_d;
    rd_first_q   <= rd_first_d;
    rd_last_q    <= rd_last_d;
    sq_r_q       <= sq_diff(pr_q, rd_q[39:32]);
    sq_g_q       <= sq_diff(pg_q, rd_q[31:24]);
    sq_b_q       <= sq_diff(pb_q, rd_q[23:16]);
    s2_glyph_q   <= rd_q[15:8];
    s2_attr_q    <= rd_q[7:0];
    s2_first_q   <= rd_first_q;
    s2_last_q    <= rd_last_q;
    best_q       <= best_d;
    pick_glyph_q <= pick_glyph_d;
    pick_attr_q  <= pick_attr_d;
    res_q        <= res_d;
  end

  // single-port palette store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_q <= mem[mem_addr];
  end

endmodule

>>> hw/rtl/npq_checker.sv
module npq_checker
  import npq_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start_i,
  input item_t   item_i,
  input logic    busy_o,
  input logic    valid_o,
  input result_t result_o
);

  // dropped load carries no glyph or attribute
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.status == STATUS_FULL
      |-> result_o.glyph_out == '0 && result_o.attribute_out == '0)
    else $error("full-bucket result has nonzero payload");

  // empty bucket gives zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.status == STATUS_EMPTY
      |-> result_o.glyph_out == '0 && result_o.attribute_out == '0)
    else $error("empty-bucket result has nonzero payload");

  // nothing comes out right after reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !valid_o && !busy_o)
    else $error("activity right after reset");

  // a result always carries one of the defined status codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> result_o.status == STATUS_OK || result_o.status == STATUS_EMPTY
      || result_o.status == STATUS_FULL)
    else $error("result with undefined status");

  // an accepted transaction carries a known payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> !$isunknown(item_i))
    else $error("accepted transaction with unknown payload");

endmodule

bind nearest_palette_color_quantizer_top npq_checker u_npq_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .item_i   (item_i),
  .busy_o   (busy_o),
  .valid_o  (valid_o),
  .result_o (result_o)
);
